// ===== hw/rtl/boq_pkg.sv =====
// Shared constants, codes and types for the branch outcome queue.
package boq_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = 7;
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam int FUNC_W = 3;
  localparam int PICK_W = 6;
  localparam int SLOT_W = 6;
  localparam int ERR_W  = 2;
  localparam int FILL_W = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 3'd0,
    FUNC_POP     = 3'd1,
    FUNC_COMMIT  = 3'd2,
    FUNC_RECOVER = 3'd3,
    FUNC_FLUSH   = 3'd4
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_ORDER = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_LIMIT     = 1'b0,
    CFG_INDIRECT_LIMIT = 1'b1
  } cfg_idx_t;

  localparam logic [LIM_W-1:0] SIZE_LIMIT_RST     = 7'd64;
  localparam logic [LIM_W-1:0] INDIRECT_LIMIT_RST = 7'd16;

  typedef struct packed {
    logic [LIM_W-1:0] size_limit;
    logic [LIM_W-1:0] indirect_limit;
  } limits_t;

  // count >= limit, both zero extended
  function automatic logic cnt_ge_lim(input logic [CNT_W-1:0] cnt,
                                      input logic [LIM_W-1:0] lim);
    return CMP_W'(cnt) >= CMP_W'(lim);
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(DEPTH - 1)) ? '0 : s + PTR_W'(1);
  endfunction

endpackage

// ===== hw/rtl/branch_outcome_queue_top.sv =====
// A transaction is captured at acceptance, runs in the execute state, and its result is registered.
// No transaction is accepted while busy is high; busy is high for the execute cycle, which
//   waits on the registered read of the per-slot indirect flag RAM.
// Results cannot be stalled; out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous): pointers and counts cleared, limits back to 64 and 16.
//   The flag RAM is not cleared; a slot's flag is read at each acceptance but used only once a push wrote it.
module branch_outcome_queue_top import boq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic                 in_is_indirect,
  input  logic [PICK_W-1:0]    in_slot_pick,
  input  logic                 in_slot_is_sync,
  output logic                 out_valid,
  output logic                 out_accepted,
  output logic [SLOT_W-1:0]    out_slot_index,
  output logic [ERR_W-1:0]     out_error_code,
  output logic [FILL_W-1:0]    out_fill_count,
  output logic                 out_not_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_wdata
);

  limits_t          limits_r;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic             ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic             ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.size_limit     <= SIZE_LIMIT_RST;
      limits_r.indirect_limit <= INDIRECT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIZE_LIMIT:     limits_r.size_limit     <= cfg_wdata;
        CFG_INDIRECT_LIMIT: limits_r.indirect_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  boq_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .limits          (limits_r),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_is_indirect  (in_is_indirect),
    .in_slot_pick    (in_slot_pick),
    .in_slot_is_sync (in_slot_is_sync),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_slot_index  (out_slot_index),
    .out_error_code  (out_error_code),
    .out_fill_count  (out_fill_count),
    .out_not_ready   (out_not_ready)
  );

  boq_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hw/rtl/boq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module boq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/boq_core.sv =====
// Pointer/count state, operation sequencer and result registers.
module boq_core import boq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  limits_t           limits,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic              in_is_indirect,
  input  logic [PICK_W-1:0] in_slot_pick,
  input  logic              in_slot_is_sync,
  output logic              ram_we,
  output logic [PTR_W-1:0]  ram_waddr,
  output logic              ram_wdata,
  output logic              ram_re,
  output logic [PTR_W-1:0]  ram_raddr,
  input  logic              ram_rdata,
  output logic              out_valid,
  output logic              out_accepted,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [ERR_W-1:0]  out_error_code,
  output logic [FILL_W-1:0] out_fill_count,
  output logic              out_not_ready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  localparam logic [PTR_W:0] DEPTH_X = (PTR_W + 1)'(DEPTH);
  localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(DEPTH);

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0] op_func_r;
  logic              op_ind_r;
  logic [PTR_W-1:0]  op_pick_r;
  logic              op_sync_r;

  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] rhead_r, rhead_nxt;
  logic [PTR_W-1:0] chead_r, chead_nxt;
  logic [CNT_W-1:0] unread_r, unread_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] ind_cnt_r, ind_cnt_nxt;

  logic              valid_r;
  logic              acc_r, acc_nxt;
  logic [PTR_W-1:0]  slot_r, slot_nxt;
  err_t              err_r, err_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic              nrdy_r, nrdy_nxt;

  logic              accept;
  logic              exec;
  logic [PTR_W-1:0]  target;
  logic [PTR_W:0]    diff;
  logic [PTR_W-1:0]  steps;
  logic [CNT_W:0]    unread_sum;

  assign accept = start && (state_r == ST_IDLE);
  assign exec   = (state_r == ST_EXEC);
  assign busy   = exec;

  // Slot flag lookup is issued at acceptance; only a commit of the head uses it.
  assign ram_re    = accept;
  assign ram_raddr = chead_r;

  // Recover: walk-back distance from the read head to the slot after the pick
  assign target     = next_slot(op_pick_r);
  assign diff       = {1'b0, rhead_r} - {1'b0, target};
  assign steps      = diff[PTR_W] ? PTR_W'(diff + DEPTH_X) : diff[PTR_W-1:0];
  assign unread_sum = {1'b0, unread_r} + (CNT_W + 1)'(steps);

  always_comb begin
    state_nxt   = state_r;
    tail_nxt    = tail_r;
    rhead_nxt   = rhead_r;
    chead_nxt   = chead_r;
    unread_nxt  = unread_r;
    total_nxt   = total_r;
    ind_cnt_nxt = ind_cnt_r;
    acc_nxt     = 1'b0;
    slot_nxt    = '0;
    err_nxt     = ERR_NONE;
    ram_we      = 1'b0;
    ram_waddr   = tail_r;
    ram_wdata   = op_ind_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (op_func_r)
          FUNC_PUSH: begin
            if (cnt_ge_lim(total_r, limits.size_limit) ||
                (total_r >= CNT_W'(DEPTH))) begin
              err_nxt = ERR_FULL;
            end else begin
              slot_nxt  = tail_r;
              ram_we    = 1'b1;
              if (unread_r < CNT_W'(DEPTH)) begin
                unread_nxt = unread_r + CNT_W'(1);
              end
              total_nxt = total_r + CNT_W'(1);
              if (op_ind_r) begin
                ind_cnt_nxt = ind_cnt_r + CNT_W'(1);
              end
              tail_nxt  = next_slot(tail_r);
              acc_nxt   = 1'b1;
            end
          end
          FUNC_POP: begin
            if (unread_r == '0) begin
              err_nxt = ERR_EMPTY;
            end else begin
              slot_nxt   = rhead_r;
              unread_nxt = unread_r - CNT_W'(1);
              rhead_nxt  = next_slot(rhead_r);
              acc_nxt    = 1'b1;
            end
          end
          FUNC_COMMIT: begin
            if (op_pick_r != chead_r) begin
              // barrier/lock slots may be named early; ignored quietly
              if (!op_sync_r) begin
                err_nxt = ERR_ORDER;
              end
            end else if (total_r == '0) begin
              err_nxt = ERR_ORDER;
            end else begin
              if (ram_rdata && (ind_cnt_r != '0)) begin
                ind_cnt_nxt = ind_cnt_r - CNT_W'(1);
              end
              chead_nxt = next_slot(chead_r);
              total_nxt = total_r - CNT_W'(1);
              acc_nxt   = 1'b1;
            end
          end
          FUNC_RECOVER: begin
            unread_nxt = (unread_sum > DEPTH_C) ? CNT_W'(DEPTH) : unread_sum[CNT_W-1:0];
            rhead_nxt  = target;
            acc_nxt    = 1'b1;
          end
          FUNC_FLUSH: begin
            tail_nxt    = '0;
            rhead_nxt   = '0;
            chead_nxt   = '0;
            unread_nxt  = '0;
            total_nxt   = '0;
            ind_cnt_nxt = '0;
            acc_nxt     = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    nrdy_nxt = cnt_ge_lim(total_nxt, limits.size_limit) ||
               cnt_ge_lim(ind_cnt_nxt, limits.indirect_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tail_r    <= '0;
      rhead_r   <= '0;
      chead_r   <= '0;
      unread_r  <= '0;
      total_r   <= '0;
      ind_cnt_r <= '0;
      valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tail_r    <= tail_nxt;
      rhead_r   <= rhead_nxt;
      chead_r   <= chead_nxt;
      unread_r  <= unread_nxt;
      total_r   <= total_nxt;
      ind_cnt_r <= ind_cnt_nxt;
      valid_r   <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r <= in_func;
      op_ind_r  <= in_is_indirect;
      op_pick_r <= PTR_W'(in_slot_pick);
      op_sync_r <= in_slot_is_sync;
    end
    if (exec) begin
      acc_r  <= acc_nxt;
      slot_r <= slot_nxt;
      err_r  <= err_nxt;
      fill_r <= total_nxt;
      nrdy_r <= nrdy_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_accepted   = acc_r;
  assign out_slot_index = SLOT_W'(slot_r);
  assign out_error_code = err_r;
  assign out_fill_count = FILL_W'(fill_r);
  assign out_not_ready  = nrdy_r;

endmodule

// ===== hw/rtl/boq_chk.sv =====
// Port-level checks for the branch outcome queue, bound to the top level.
module boq_chk import boq_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [FUNC_W-1:0]    in_func,
  input logic                 in_is_indirect,
  input logic [PICK_W-1:0]    in_slot_pick,
  input logic                 in_slot_is_sync,
  input logic                 out_valid,
  input logic                 out_accepted,
  input logic [SLOT_W-1:0]    out_slot_index,
  input logic [ERR_W-1:0]     out_error_code,
  input logic [FILL_W-1:0]    out_fill_count,
  input logic                 out_not_ready,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [LIM_W-1:0]     cfg_wdata
);

  // every accepted transaction goes busy for exactly one cycle, then reports
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle did not produce exactly one result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_count <= FILL_W'(DEPTH)))
    else $error("fill count beyond queue depth");

  a_err_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code != ERR_NONE)) |-> !out_accepted)
    else $error("transaction reported both accepted and an error");

endmodule

bind branch_outcome_queue_top boq_chk u_boq_chk (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the branch outcome queue: stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module tb_top import boq_pkg::*; ();

  localparam int CLK_PERIOD    = 10;
  localparam int RST_CYCLES    = 6;
  localparam int SETTLE_CYCLES = 2;
  localparam int DRAIN_CYCLES  = 4;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int MAX_REPORTS   = 40;
  localparam int NUM_PHASES    = 7;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

  typedef enum logic {ENTRY_OP, ENTRY_CFG} entry_kind_t;
  // how slot_pick is chosen when the command reaches the port
  typedef enum logic [1:0] {PICK_AS_IS, PICK_COMMIT_HEAD, PICK_OUTSTANDING} pick_mode_t;

  typedef struct {
    entry_kind_t       kind;
    logic [FUNC_W-1:0] func;
    logic              ind;
    logic [PICK_W-1:0] pick;
    logic              sync;
    pick_mode_t        mode;
    cfg_idx_t          idx;
    logic [LIM_W-1:0]  val;
  } branch_cmd_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    err_t              err;
    logic [FILL_W-1:0] fill;
    logic              not_ready;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func = '0;
  logic                 in_is_indirect = 1'b0;
  logic [PICK_W-1:0]    in_slot_pick = '0;
  logic                 in_slot_is_sync = 1'b0;
  logic                 out_valid;
  logic                 out_accepted;
  logic [SLOT_W-1:0]    out_slot_index;
  logic [ERR_W-1:0]     out_error_code;
  logic [FILL_W-1:0]    out_fill_count;
  logic                 out_not_ready;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIM_W-1:0]     cfg_wdata = '0;

  branch_outcome_queue_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_is_indirect  (in_is_indirect),
    .in_slot_pick    (in_slot_pick),
    .in_slot_is_sync (in_slot_is_sync),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_slot_index  (out_slot_index),
    .out_error_code  (out_error_code),
    .out_fill_count  (out_fill_count),
    .out_not_ready   (out_not_ready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  branch_cmd_t branch_cmds[$];
  outcome_t    expected_outcomes[$];

  // shadow queue state
  int   q_tail = 0, q_rhead = 0, q_chead = 0;
  int   q_unread = 0, q_total = 0, q_indirect = 0;
  logic q_flag[DEPTH];
  int   lim_size = int'(SIZE_LIMIT_RST);
  int   lim_ind  = int'(INDIRECT_LIMIT_RST);

  int   cycle_count = 0;
  int   fail_count = 0;
  int   n_checked = 0, n_push_ok = 0, n_push_full = 0, n_commit_ok = 0;
  int   n_recover = 0, n_flush = 0, n_cfg = 0;

  logic xact_taken = 1'b0;
  logic holding = 1'b0;
  int   rst_hold = 0;
  int   settle = 0;
  int   burst_left = 8;
  int   gap_left = 0;

  task automatic flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch on result %0d: %s", $time, n_checked, msg);
  endtask

  task automatic predict_outcome(input logic [FUNC_W-1:0] f, input logic ind,
                                 input logic [PICK_W-1:0] pick_raw, input logic sync);
    outcome_t want;
    int pick, target, steps;
    want = '0;
    want.err = ERR_NONE;
    pick = int'(pick_raw) % DEPTH;
    case (f)
      FUNC_PUSH: begin
        if (q_total >= lim_size || q_total >= DEPTH) begin
          want.err = ERR_FULL;
          n_push_full++;
        end else begin
          want.slot = SLOT_W'(q_tail);
          q_flag[q_tail] = ind;
          if (q_unread < DEPTH) q_unread++;
          q_total++;
          if (ind) q_indirect++;
          q_tail = (q_tail + 1) % DEPTH;
          want.accepted = 1'b1;
          n_push_ok++;
        end
      end
      FUNC_POP: begin
        if (q_unread == 0) begin
          want.err = ERR_EMPTY;
        end else begin
          want.slot = SLOT_W'(q_rhead);
          q_unread--;
          q_rhead = (q_rhead + 1) % DEPTH;
          want.accepted = 1'b1;
        end
      end
      FUNC_COMMIT: begin
        if (pick != q_chead) begin
          // barrier or lock in another slot is silently skipped
          if (!sync) want.err = ERR_ORDER;
        end else if (q_total == 0) begin
          want.err = ERR_ORDER;
        end else begin
          if (q_flag[pick] && q_indirect > 0) q_indirect--;
          q_chead = (q_chead + 1) % DEPTH;
          q_total--;
          want.accepted = 1'b1;
          n_commit_ok++;
        end
      end
      FUNC_RECOVER: begin
        target = (pick + 1) % DEPTH;
        steps = (q_rhead + DEPTH - target) % DEPTH;
        q_unread += steps;
        if (q_unread > DEPTH) q_unread = DEPTH;
        q_rhead = target;
        want.accepted = 1'b1;
        n_recover++;
      end
      FUNC_FLUSH: begin
        q_tail = 0;
        q_rhead = 0;
        q_chead = 0;
        q_unread = 0;
        q_total = 0;
        q_indirect = 0;
        want.accepted = 1'b1;
        n_flush++;
      end
      default: ;
    endcase
    want.fill = FILL_W'(q_total);
    want.not_ready = (q_total >= lim_size) || (q_indirect >= lim_ind);
    expected_outcomes.push_back(want);
  endtask

  task automatic queue_op(input logic [FUNC_W-1:0] f, input logic ind,
                          input logic [PICK_W-1:0] pick, input logic sync,
                          input pick_mode_t mode);
    branch_cmd_t c;
    c.kind = ENTRY_OP;
    c.func = f;
    c.ind  = ind;
    c.pick = pick;
    c.sync = sync;
    c.mode = mode;
    c.idx  = CFG_SIZE_LIMIT;
    c.val  = '0;
    branch_cmds.push_back(c);
  endtask

  task automatic queue_cfg(input cfg_idx_t idx, input int val);
    branch_cmd_t c;
    c.kind = ENTRY_CFG;
    c.func = FUNC_PUSH;
    c.ind  = 1'b0;
    c.pick = '0;
    c.sync = 1'b0;
    c.mode = PICK_AS_IS;
    c.idx  = idx;
    c.val  = LIM_W'(val);
    branch_cmds.push_back(c);
  endtask

  // mostly well-formed traffic: pushes, in-order pops and commits, recovers
  // to a popped slot; the rest is misdirected commits, stray recovers, noise
  task automatic queue_random_op(input int push_w);
    int roll;
    logic ind, sync;
    logic [PICK_W-1:0] pick;
    roll = $urandom_range(0, 99);
    ind  = ($urandom_range(0, 2) == 0);
    sync = 1'($urandom_range(0, 1));
    pick = PICK_W'($urandom_range(0, 63));
    if (roll < push_w)                  queue_op(FUNC_PUSH, ind, pick, sync, PICK_AS_IS);
    else if (roll < push_w + 22)        queue_op(FUNC_POP, ind, pick, sync, PICK_AS_IS);
    else if (roll < push_w + 26)        queue_op(FUNC_COMMIT, ind, pick, sync, PICK_AS_IS);
    else if (roll < push_w + 32)        queue_op(FUNC_RECOVER, ind, pick, sync, PICK_OUTSTANDING);
    else if (roll < push_w + 34)        queue_op(FUNC_RECOVER, ind, pick, sync, PICK_AS_IS);
    else if (roll < push_w + 35)        queue_op(FUNC_FLUSH, ind, pick, sync, PICK_AS_IS);
    else if (roll < push_w + 37)
      queue_op(FUNC_W'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST)), ind, pick, sync,
               PICK_AS_IS);
    else                                queue_op(FUNC_COMMIT, ind, pick, sync, PICK_COMMIT_HEAD);
  endtask

  // driver: one command in flight; config writes wait for an idle block
  always @(negedge clk) begin
    branch_cmd_t c;
    logic nx_start, nx_we;
    int span;
    nx_start = 1'b0;
    nx_we = 1'b0;
    if (rst_hold < RST_CYCLES) begin
      rst_hold++;
    end else begin
      if (xact_taken) holding = 1'b0;
      if (holding) begin
        nx_start = 1'b1;
      end else if (branch_cmds.size() > 0) begin
        if (branch_cmds[0].kind == ENTRY_CFG) begin
          settle = (expected_outcomes.size() == 0 && busy === 1'b0) ? settle + 1 : 0;
          if (settle > SETTLE_CYCLES) begin
            c = branch_cmds.pop_front();
            cfg_index <= c.idx;
            cfg_wdata <= c.val;
            nx_we = 1'b1;
            settle = 0;
            n_cfg++;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          c = branch_cmds.pop_front();
          // shadow state is current here: nothing else can be accepted first
          case (c.mode)
            PICK_COMMIT_HEAD: c.pick = PICK_W'(q_chead);
            PICK_OUTSTANDING: begin
              span = (q_rhead + DEPTH - q_chead) % DEPTH;
              if (span > 0) c.pick = PICK_W'((q_chead + $urandom_range(0, span - 1)) % DEPTH);
            end
            default: ;
          endcase
          in_func <= c.func;
          in_is_indirect <= c.ind;
          in_slot_pick <= c.pick;
          in_slot_is_sync <= c.sync;
          nx_start = 1'b1;
          holding = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    rst_n <= (rst_hold >= RST_CYCLES);
    start <= nx_start;
    cfg_we <= nx_we;
  end

  // monitor: capture accepted transactions and config writes, check results
  always @(posedge clk) begin
    outcome_t want;
    cycle_count++;
    xact_taken <= rst_n && start && !busy;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        flag_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        n_checked++;
        if (out_accepted !== want.accepted)
          flag_mismatch($sformatf("accepted %b, want %b", out_accepted, want.accepted));
        if (out_slot_index !== want.slot)
          flag_mismatch($sformatf("slot_index %0d, want %0d", out_slot_index, want.slot));
        if (out_error_code !== want.err)
          flag_mismatch($sformatf("error_code %0d, want %0d", out_error_code, want.err));
        if (out_fill_count !== want.fill)
          flag_mismatch($sformatf("fill_count %0d, want %0d", out_fill_count, want.fill));
        if (out_not_ready !== want.not_ready)
          flag_mismatch($sformatf("not_ready %b, want %b", out_not_ready, want.not_ready));
      end
    end
    if (rst_n && cfg_we) begin
      if (cfg_index == CFG_SIZE_LIMIT) lim_size = int'(cfg_wdata);
      else lim_ind = int'(cfg_wdata);
    end
    if (rst_n && start && !busy)
      predict_outcome(in_func, in_is_indirect, in_slot_pick, in_slot_is_sync);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    static int ph_len[NUM_PHASES]  = '{130, 130, 130, 100, 30, 120, 120};
    static int ph_push[NUM_PHASES] = '{33, 41, 41, 25, 33, 33, 41};
    static int ph_size[NUM_PHASES] = '{64, 8, 127, 1, 0, 0, 64};
    static int ph_ind[NUM_PHASES]  = '{16, 3, 127, 1, 0, 0, 64};
    int sz, il;

    // directed: empty and out-of-order cases, wraparound recover, unused function codes, flush
    queue_op(FUNC_POP, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b1, '1, 1'b1, PICK_AS_IS);
    queue_op(FUNC_PUSH, 1'b1, '1, 1'b1, PICK_AS_IS);
    queue_op(FUNC_PUSH, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_PUSH, 1'b1, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_POP, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_POP, 1'b1, '1, 1'b1, PICK_AS_IS);
    queue_op(FUNC_RECOVER, 1'b0, '1, 1'b0, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b0, 6'd5, 1'b1, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b0, 6'd5, 1'b0, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b0, '0, 1'b0, PICK_COMMIT_HEAD);
    queue_op(FUNC_RECOVER, 1'b1, '0, 1'b1, PICK_AS_IS);
    queue_op(FUNC_PUSH, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_POP, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_UNUSED_LAST, 1'b1, '1, 1'b1, PICK_AS_IS);
    queue_op(FUNC_UNUSED_FIRST, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_FLUSH, 1'b1, '1, 1'b1, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b0, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_PUSH, 1'b1, '0, 1'b0, PICK_AS_IS);
    queue_op(FUNC_COMMIT, 1'b0, '0, 1'b0, PICK_COMMIT_HEAD);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sz = ph_size[ph];
      il = ph_ind[ph];
      if (ph == 5) begin
        sz = $urandom_range(1, 64);
        il = $urandom_range(1, 64);
      end
      queue_cfg(CFG_SIZE_LIMIT, sz);
      queue_cfg(CFG_INDIRECT_LIMIT, il);
      for (int i = 0; i < ph_len[ph]; i++) queue_random_op(ph_push[ph]);
    end

    while (branch_cmds.size() != 0 || holding || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d pushes taken, %0d refused full, %0d commits, %0d recovers",
             n_checked, n_push_ok, n_push_full, n_commit_ok, n_recover);
    $display("%0d flushes, %0d limit register writes, %0d mismatches",
             n_flush, n_cfg, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/boq_pkg.sv
hw/rtl/boq_ram.sv
hw/rtl/boq_core.sv
hw/rtl/branch_outcome_queue_top.sv
hw/rtl/boq_chk.sv
test/tb_top.sv
